// File: sv/homogeneous_point_transform_top_assert.svh
// Assertion macros for the homogeneous point transform checker.
// No dependencies; included by the checker file.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_TOP_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_TOP_ASSERT_SVH

// checked outside reset
`define HPT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define HPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/hpt_pkg.sv
// Shared widths, types and register codes for the homogeneous point transform.
// No dependencies; used by the interfaces, the top level and the checker.
package hpt_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int COEF_WIDTH      = 16;
   localparam int COEF_FRAC       = COEF_WIDTH - 4;
   localparam int NUM_AXES        = 3;
   localparam int ROW_WIDTH       = NUM_AXES * COEF_WIDTH;
   localparam int CSR_DATA_WIDTH  = (ROW_WIDTH > COORD_WIDTH) ? ROW_WIDTH : COORD_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int PROD_WIDTH      = COORD_WIDTH + COEF_WIDTH;
   localparam int SUM_WIDTH       = PROD_WIDTH + 2;
   localparam int SHR_WIDTH       = SUM_WIDTH - COEF_FRAC;
   localparam int RES_WIDTH       = SHR_WIDTH + 1;

   typedef logic signed [COORD_WIDTH-1:0]    coord_type;
   typedef logic signed [COEF_WIDTH-1:0]     coef_type;
   typedef logic        [ROW_WIDTH-1:0]      row_type;
   typedef logic        [CSR_DATA_WIDTH-1:0] csr_data_type;
   typedef logic signed [PROD_WIDTH-1:0]     prod_type;
   typedef logic signed [SUM_WIDTH-1:0]      sum_type;
   typedef logic signed [SHR_WIDTH-1:0]      shr_type;
   typedef logic signed [RES_WIDTH-1:0]      res_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ROW_X   = 3'd0,
      REG_ROW_Y   = 3'd1,
      REG_ROW_Z   = 3'd2,
      REG_SHIFT_X = 3'd3,
      REG_SHIFT_Y = 3'd4,
      REG_SHIFT_Z = 3'd5
   } csr_index_type;

   localparam row_type   COEF_ONE  = row_type'(1) << COEF_FRAC;
   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

endpackage

// File: sv/hpt_req_if.sv
// Point input channel: valid/ready plus one 3D point.
// Depends on hpt_pkg.
interface hpt_req_if import hpt_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type in_x;
   coord_type in_y;
   coord_type in_z;

   modport source (output valid, in_x, in_y, in_z, input ready);
   modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

// File: sv/hpt_rsp_if.sv
// Result channel: valid/ready plus the transformed point and clip flag.
// Depends on hpt_pkg.
interface hpt_rsp_if import hpt_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   logic      clipped;

   modport source (output valid, out_x, out_y, out_z, clipped, input ready);
   modport sink   (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

// File: sv/hpt_csr_if.sv
// Register write channel: valid/ready, register index and write data.
// Depends on hpt_pkg.
interface hpt_csr_if import hpt_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   csr_data_type               data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/homogeneous_point_transform_top.sv
// Homogeneous point transform: 3x3 linear part plus translation, saturated.
// Depends on hpt_pkg, hpt_req_if, hpt_rsp_if and hpt_csr_if.
//
//   channel   dir   payload                        transfer when
//   req_bus   in    in_x, in_y, in_z               valid & ready
//   rsp_bus   out   out_x, out_y, out_z, clipped   valid & ready
//   csr_bus   in    index, data                    valid & ready (ready tied high)
//
// One point per cycle while rsp_bus does not stall; from request transfer to result
// valid it passes stage 1 the nine coefficient products, stage 2 the row sums, stage 3
// the shift, translation and saturation, which is also the output register.
// Reset clears the stage valid bits and loads the identity transform.
// A stall on rsp_bus lets stages behind an empty slot keep filling.
module homogeneous_point_transform_top import hpt_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   hpt_req_if.sink   req_bus,
   hpt_rsp_if.source rsp_bus,
   hpt_csr_if.sink   csr_bus
);

   row_type   row_ff   [NUM_AXES];
   row_type   row_in   [NUM_AXES];
   coord_type shift_ff [NUM_AXES];
   coord_type shift_in [NUM_AXES];

   logic     v1_ff, v1_in;
   prod_type prod_ff [NUM_AXES][NUM_AXES];
   prod_type prod_in [NUM_AXES][NUM_AXES];

   logic    v2_ff, v2_in;
   sum_type sum_ff [NUM_AXES];
   sum_type sum_in [NUM_AXES];

   logic      v3_ff, v3_in;
   coord_type out_ff [NUM_AXES];
   coord_type out_in [NUM_AXES];
   logic      clip_ff, clip_in;

   logic en1, en2, en3;
   coord_type pt [NUM_AXES];
   logic      sat [NUM_AXES];

   assign en3 = !v3_ff || rsp_bus.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_bus.ready = en1;
   assign csr_bus.ready = 1'b1;

   assign pt[0] = req_bus.in_x;
   assign pt[1] = req_bus.in_y;
   assign pt[2] = req_bus.in_z;

   // register file
   always_comb begin
      row_in   = row_ff;
      shift_in = shift_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_ROW_X:   row_in[0]   = csr_bus.data[ROW_WIDTH-1:0];
            REG_ROW_Y:   row_in[1]   = csr_bus.data[ROW_WIDTH-1:0];
            REG_ROW_Z:   row_in[2]   = csr_bus.data[ROW_WIDTH-1:0];
            REG_SHIFT_X: shift_in[0] = csr_bus.data[COORD_WIDTH-1:0];
            REG_SHIFT_Y: shift_in[1] = csr_bus.data[COORD_WIDTH-1:0];
            REG_SHIFT_Z: shift_in[2] = csr_bus.data[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: products
   always_comb begin
      v1_in = en1 ? req_bus.valid : v1_ff;
      for (int r = 0; r < NUM_AXES; r++) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            prod_in[r][k] = prod_type'(coef_type'(row_ff[r][k*COEF_WIDTH +: COEF_WIDTH]))
                            * prod_type'(pt[k]);
         end
      end
   end

   // stage 2: row sums
   always_comb begin
      v2_in = en2 ? v1_ff : v2_ff;
      for (int r = 0; r < NUM_AXES; r++) begin
         sum_in[r] = sum_type'(prod_ff[r][0]) + sum_type'(prod_ff[r][1])
                   + sum_type'(prod_ff[r][2]);
      end
   end

   // stage 3: rescale, translate, saturate
   always_comb begin
      shr_type shr;
      res_type res;
      v3_in = en3 ? v2_ff : v3_ff;
      for (int r = 0; r < NUM_AXES; r++) begin
         shr = shr_type'(sum_ff[r] >>> COEF_FRAC);
         res = res_type'(shr) + res_type'(shift_ff[r]);
         sat[r] = 1'b1;
         if (res > res_type'(COORD_MAX)) begin
            out_in[r] = COORD_MAX;
         end else if (res < res_type'(COORD_MIN)) begin
            out_in[r] = COORD_MIN;
         end else begin
            out_in[r] = res[COORD_WIDTH-1:0];
            sat[r]    = 1'b0;
         end
      end
      clip_in = sat[0] || sat[1] || sat[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]   <= COEF_ONE;
         row_ff[1]   <= COEF_ONE << COEF_WIDTH;
         row_ff[2]   <= COEF_ONE << (2 * COEF_WIDTH);
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
      end else begin
         row_ff   <= row_in;
         shift_ff <= shift_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         prod_ff <= prod_in;
      end
      if (en2) begin
         sum_ff <= sum_in;
      end
      if (en3) begin
         out_ff  <= out_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_bus.valid   = v3_ff;
   assign rsp_bus.out_x   = out_ff[0];
   assign rsp_bus.out_y   = out_ff[1];
   assign rsp_bus.out_z   = out_ff[2];
   assign rsp_bus.clipped = clip_ff;

endmodule

// File: sv/hpt_checker.sv
// Port-level checks for homogeneous_point_transform_top, bound to the top level.
// Depends on hpt_pkg and homogeneous_point_transform_top_assert.svh.
`include "homogeneous_point_transform_top_assert.svh"

module hpt_checker import hpt_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input coord_type out_x,
   input coord_type out_y,
   input coord_type out_z,
   input logic      clipped
);

   `HPT_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")

   `HPT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(clipped), "stalled result changed")

   `HPT_ASSERT(a_clip_at_limit, clock, reset, rsp_valid && clipped |-> out_x == COORD_MAX || out_x == COORD_MIN || out_y == COORD_MAX || out_y == COORD_MIN || out_z == COORD_MAX || out_z == COORD_MIN, "clip flag without a saturated coordinate")

   `HPT_ASSERT(a_no_req_stall_when_drained, clock, reset, req_valid && !rsp_valid |-> req_ready, "input stalled with empty output")

endmodule

bind homogeneous_point_transform_top hpt_checker u_hpt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .out_x     (rsp_bus.out_x),
   .out_y     (rsp_bus.out_y),
   .out_z     (rsp_bus.out_z),
   .clipped   (rsp_bus.clipped)
);

// File: verif/testbench.sv
// Self-checking testbench for homogeneous_point_transform_top: streams points through
// the transform under several register settings and random flow control.
// Depends on hpt_pkg, hpt_req_if, hpt_rsp_if, hpt_csr_if and the top level.
module testbench import hpt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 300000;
   localparam int TAIL_CYCLES    = 8;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_POINTS   = 55;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 3'd7;

   localparam coef_type COEF_MAX  = 16'sh7FFF;
   localparam coef_type COEF_MIN  = 16'sh8000;
   localparam coef_type COEF_UNIT = 16'sh1000;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      clipped;
   } point_result_type;

   typedef enum int {
      STYLE_WIDE,
      STYLE_MODEST,
      STYLE_EXTREME,
      STYLE_IDENTITY
   } transform_style_type;

   logic clock;
   logic reset;

   hpt_req_if req_bus ();
   hpt_rsp_if rsp_bus ();
   hpt_csr_if csr_bus ();

   homogeneous_point_transform_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   row_type          coef_rows [NUM_AXES];
   coord_type        translation [NUM_AXES];
   point_result_type expected_points [$];
   int unsigned      sent_count    = 0;
   int unsigned      checked_count = 0;
   int unsigned      error_count   = 0;
   int unsigned      cycle_count   = 0;
   int               rsp_hold      = 0;
   bit               idle_on       = 1'b1;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic coord_type small_coord();
      return coord_type'(int'($urandom_range(0, 2097151)) - 1048576);
   endfunction

   function automatic coord_type random_coord();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return coord_type'($urandom);
      if (roll < 65) return small_coord();
      if (roll < 85) return coord_type'(int'($urandom_range(0, 134217727)) - 67108864);
      case ($urandom_range(0, 4))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return '0;
         3:       return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   function automatic coef_type random_coef(transform_style_type style, bit on_diag);
      case (style)
         STYLE_WIDE:   return coef_type'($urandom);
         STYLE_MODEST: return coef_type'(int'($urandom_range(0, 12287)) - 6144);
         STYLE_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return COEF_MAX;
               1:       return COEF_MIN;
               2:       return '0;
               3:       return COEF_UNIT;
               default: return -COEF_UNIT;
            endcase
         end
         default:      return on_diag ? COEF_UNIT : coef_type'(0);
      endcase
   endfunction

   function automatic coord_type random_translation(transform_style_type style);
      case (style)
         STYLE_WIDE: return coord_type'($urandom);
         STYLE_EXTREME: begin
            case ($urandom_range(0, 2))
               0:       return COORD_MAX;
               1:       return COORD_MIN;
               default: return '0;
            endcase
         end
         default:    return small_coord();
      endcase
   endfunction

   function automatic row_type pack_row(coef_type cx, coef_type cy, coef_type cz);
      return {cz, cy, cx};
   endfunction

   // 3x3 linear part in exact 64-bit arithmetic, floor shift, translation, clamp
   function automatic point_result_type transform_point(coord_type px, coord_type py,
                                                        coord_type pz);
      longint signed    pt [NUM_AXES];
      longint signed    acc;
      coord_type        row_out [NUM_AXES];
      point_result_type res;
      pt[0] = px;
      pt[1] = py;
      pt[2] = pz;
      res.clipped = 1'b0;
      for (int r = 0; r < NUM_AXES; r++) begin
         acc = 0;
         for (int k = 0; k < NUM_AXES; k++)
            acc += longint'(coef_type'(coef_rows[r][k*COEF_WIDTH +: COEF_WIDTH])) * pt[k];
         acc = (acc >>> COEF_FRAC) + longint'(translation[r]);
         if (acc > longint'(COORD_MAX)) begin
            row_out[r] = COORD_MAX;
            res.clipped = 1'b1;
         end else if (acc < longint'(COORD_MIN)) begin
            row_out[r] = COORD_MIN;
            res.clipped = 1'b1;
         end else begin
            row_out[r] = coord_type'(acc);
         end
      end
      res.x = row_out[0];
      res.y = row_out[1];
      res.z = row_out[2];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [COORD_WIDTH-1:0] got,
                                  logic [COORD_WIDTH-1:0] want);
      error_count++;
      $display("%0t: %s mismatch at result %0d: got %h, expected %h",
               $time, what, checked_count, got, want);
   endtask

   // transfers on all three channels, sampled at the edge
   always @(posedge clock) begin : result_monitor
      point_result_type want;
      if (reset) begin
         coef_rows[0]   = COEF_ONE;
         coef_rows[1]   = COEF_ONE << COEF_WIDTH;
         coef_rows[2]   = COEF_ONE << (2 * COEF_WIDTH);
         translation[0] = '0;
         translation[1] = '0;
         translation[2] = '0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_points.insert(expected_points.size(),
                                   transform_point(req_bus.in_x, req_bus.in_y,
                                                   req_bus.in_z));
         if (rsp_bus.valid && rsp_bus.ready) begin
            checked_count++;
            if (expected_points.size() == 0) begin
               report_mismatch("unexpected result", rsp_bus.out_x, '0);
            end else begin
               want = expected_points.pop_front();
               if (rsp_bus.out_x !== want.x) report_mismatch("out_x", rsp_bus.out_x, want.x);
               if (rsp_bus.out_y !== want.y) report_mismatch("out_y", rsp_bus.out_y, want.y);
               if (rsp_bus.out_z !== want.z) report_mismatch("out_z", rsp_bus.out_z, want.z);
               if (rsp_bus.clipped !== want.clipped)
                  report_mismatch("clipped", COORD_WIDTH'(rsp_bus.clipped),
                                  COORD_WIDTH'(want.clipped));
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_ROW_X, REG_ROW_Y, REG_ROW_Z:
                  coef_rows[csr_bus.index[1:0]] = csr_bus.data[ROW_WIDTH-1:0];
               REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z:
                  translation[2'(csr_bus.index - REG_SHIFT_X)] =
                     csr_bus.data[COORD_WIDTH-1:0];
               default: ;
            endcase
         end
      end
   end

   // result backpressure
   always @(posedge clock) begin
      if (reset || rsp_hold == 0) begin
         rsp_bus.ready <= 1'b1;
         rsp_hold      <= idle_on ? pick_gap() : 0;
      end else begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= rsp_hold - 1;
      end
   end

   // valid is left high when no gap follows, so back-to-back points stream
   task automatic send_point(coord_type px, coord_type py, coord_type pz);
      int gap;
      req_bus.in_x  <= px;
      req_bus.in_y  <= py;
      req_bus.in_z  <= pz;
      req_bus.valid <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_count++;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_points();
      req_bus.valid <= 1'b0;
      wait (checked_count == sent_count);
   endtask

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] index, csr_data_type value);
      csr_bus.index <= index;
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   task automatic end_register_writes();
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_random_transform(transform_style_type style);
      coef_type  c [NUM_AXES];
      coord_type t;
      for (int r = 0; r < NUM_AXES; r++) begin
         for (int k = 0; k < NUM_AXES; k++)
            c[k] = random_coef(style, r == k);
         write_register(CSR_INDEX_WIDTH'(int'(REG_ROW_X) + r), pack_row(c[0], c[1], c[2]));
      end
      for (int r = 0; r < NUM_AXES; r++) begin
         t = random_translation(style);
         write_register(CSR_INDEX_WIDTH'(int'(REG_SHIFT_X) + r), {16'($urandom), t});
      end
      end_register_writes();
   endtask

   task automatic test_identity_after_reset();
      send_point('0, '0, '0);
      send_point(COORD_MAX, COORD_MIN, -32'sd1);
      send_point(32'sd1, -32'sd65536, 32'sd12345);
      drain_points();
   endtask

   task automatic test_saturation();
      write_register(REG_ROW_X, pack_row(COEF_MAX, COEF_MAX, COEF_MAX));
      write_register(REG_ROW_Y, pack_row(COEF_MAX, COEF_MAX, COEF_MAX));
      write_register(REG_ROW_Z, pack_row(COEF_MAX, COEF_MAX, COEF_MAX));
      write_register(REG_SHIFT_X, {16'h0000, COORD_MAX});
      write_register(REG_SHIFT_Y, {16'h0000, COORD_MIN});
      write_register(REG_SHIFT_Z, '0);
      end_register_writes();
      send_point(COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_point('0, '0, '0);
      send_point(32'sd1, 32'sd1, 32'sd1);
      drain_points();
      // bits above the translation width must be dropped
      write_register(REG_ROW_X, pack_row(COEF_MIN, COEF_MIN, COEF_MIN));
      write_register(REG_ROW_Y, pack_row(COEF_MIN, COEF_MIN, COEF_MIN));
      write_register(REG_ROW_Z, pack_row(COEF_MIN, COEF_MIN, COEF_MIN));
      write_register(REG_SHIFT_X, {16'hFFFF, 32'h0000_0000});
      write_register(REG_SHIFT_Y, {16'hA5A5, 32'h0000_0000});
      write_register(REG_SHIFT_Z, {16'h5A5A, 32'h0000_0000});
      end_register_writes();
      send_point(COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(-32'sd1, -32'sd1, -32'sd1);
      drain_points();
   endtask

   task automatic test_rounding_and_spare_index();
      write_register(REG_ROW_X, pack_row(16'sd1, '0, '0));
      write_register(REG_ROW_Y, pack_row('0, -16'sd1, '0));
      write_register(REG_ROW_Z, pack_row(COEF_UNIT, COEF_UNIT, -COEF_UNIT));
      write_register(REG_SHIFT_X, '0);
      write_register(REG_SHIFT_Y, {16'h0000, 32'sd5});
      write_register(REG_SHIFT_Z, {16'h0000, -32'sd7});
      end_register_writes();
      send_point(-32'sd1, 32'sd1, 32'sd7);
      send_point(32'sd4095, -32'sd4095, '0);
      send_point(-32'sd4097, 32'sd4096, 32'sd3);
      drain_points();
      // writes to unmapped indexes leave the transform untouched
      write_register(CSR_SPARE_LOW, '1);
      write_register(CSR_SPARE_HIGH, '1);
      end_register_writes();
      send_point(-32'sd1, 32'sd1, 32'sd7);
      send_point(COORD_MIN, COORD_MAX, 32'sd1);
      drain_points();
   endtask

   task automatic test_random_transforms();
      transform_style_type style;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase % 4) != 3;
         if (phase == 0)
            style = STYLE_EXTREME;
         else if (phase == 1)
            style = STYLE_WIDE;
         else
            style = transform_style_type'($urandom_range(STYLE_WIDE, STYLE_IDENTITY));
         load_random_transform(style);
         for (int n = 0; n < PHASE_POINTS; n++)
            send_point(random_coord(), random_coord(), random_coord());
         drain_points();
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.in_x  = '0;
      req_bus.in_y  = '0;
      req_bus.in_z  = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_identity_after_reset();
      test_saturation();
      test_rounding_and_spare_index();
      test_random_transforms();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_points.size() != 0)
         report_mismatch("missing result", '0, expected_points[0].x);
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
